// ----- hdl/sha256_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values and the control types shared by the
// controller and the datapath.
// ----------------------------------------------------------------------------
package sha256_pkg;

    localparam int WordWidth = 32;

    typedef logic [WordWidth-1:0] word_t;

    localparam word_t InitHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t RoundConst [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [5:0] LenPos  = 6'd56;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_COMP   = 7'b0000010,
        ST_PAD    = 7'b0000100,
        ST_COMP1  = 7'b0001000,
        ST_ZERO   = 7'b0010000,
        ST_COMP2  = 7'b0100000,
        ST_EMIT   = 7'b1000000
    } state_t;

    typedef struct packed {
        logic       absorb;
        logic       load_work;
        logic       round;
        logic       add_hash;
        logic       pad_first;
        logic       zero_block;
        logic       set_length;
        logic       restart;
        logic [5:0] round_idx;
    } sha_cmd_t;

    typedef struct packed {
        logic [5:0] fill;
    } sha_status_t;

endpackage

// ----- hdl/sha256_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block buffer with schedule window, working registers, hash words and the
// one-round-per-cycle compression logic.
// ----------------------------------------------------------------------------
module sha256_datapath
    import sha256_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  sha_cmd_t    cmd,
    input  logic [7:0]  byte_in,
    output sha_status_t status,
    output word_t       hash_out [8]
);

    word_t       w_reg [16];
    word_t       v_reg [8];
    word_t       h_reg [8];
    logic [5:0]  fill_reg;
    logic [31:0] len_reg;

    word_t wt, s0w, s1w, sa, se, chv, mjv, t1, t2, ww15, ww2;
    logic [3:0] wi;
    logic [4:0] sh;

    function automatic word_t rotr(input word_t x, input int n);
        rotr = (x >> n) | (x << (WordWidth - n));
    endfunction

    always_comb
    begin
        ww15 = w_reg[4'(cmd.round_idx + 6'd1)];
        ww2  = w_reg[4'(cmd.round_idx + 6'd14)];
        s0w  = rotr(ww15, 7) ^ rotr(ww15, 18) ^ (ww15 >> 3);
        s1w  = rotr(ww2, 17) ^ rotr(ww2, 19) ^ (ww2 >> 10);
        if (cmd.round_idx < 6'd16)
            wt = w_reg[cmd.round_idx[3:0]];
        else
            wt = w_reg[cmd.round_idx[3:0]] + s0w + w_reg[4'(cmd.round_idx + 6'd9)] + s1w;
        sa  = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        mjv = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        se  = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        chv = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t2  = sa + mjv;
        t1  = v_reg[7] + se + chv + RoundConst[cmd.round_idx] + wt;
        wi  = fill_reg[5:2];
        sh  = 5'((2'd3 - fill_reg[1:0]) * 8);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.absorb)
        begin
            if (fill_reg[1:0] == 2'd0)
                w_reg[wi] <= {byte_in, 24'd0};
            else
                w_reg[wi] <= (w_reg[wi] & ~(word_t'(8'hff) << sh)) | (word_t'(byte_in) << sh);
        end
        else if (cmd.round)
            w_reg[cmd.round_idx[3:0]] <= wt;
        else if (cmd.pad_first)
        begin
            for (int i = 0; i < 16; i++)
            begin
                if (4'(i) > wi)
                    w_reg[i] <= '0;
            end
            if (fill_reg[1:0] == 2'd0)
                w_reg[wi] <= {PadByte, 24'd0};
            else
                w_reg[wi] <= (w_reg[wi] & ~(word_t'(32'hffffffff) >> (5'd24 - sh)))
                             | (word_t'(PadByte) << sh);
        end
        else if (cmd.zero_block)
        begin
            for (int i = 0; i < 16; i++)
                w_reg[i] <= '0;
        end
        if (cmd.set_length)
        begin
            w_reg[14] <= '0;
            w_reg[15] <= len_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            len_reg  <= '0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= InitHash[i];
                v_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.absorb)
            begin
                fill_reg <= fill_reg + 6'd1;
                len_reg  <= len_reg + 32'd8;
            end
            if (cmd.load_work)
            begin
                for (int i = 0; i < 8; i++)
                    v_reg[i] <= h_reg[i];
            end
            else if (cmd.round)
            begin
                v_reg[7] <= v_reg[6];
                v_reg[6] <= v_reg[5];
                v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2];
                v_reg[2] <= v_reg[1];
                v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + t2;
            end
            if (cmd.add_hash)
            begin
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= h_reg[i] + v_reg[i];
            end
            if (cmd.restart)
            begin
                fill_reg <= '0;
                len_reg  <= '0;
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= InitHash[i];
            end
        end
    end

    assign status.fill = fill_reg;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
            hash_out[i] = h_reg[i];
    end

endmodule

// ----- hdl/sha256_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte absorption, compression rounds, padding and digest output.
// ----------------------------------------------------------------------------
module sha256_ctrl
    import sha256_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        byte_present,
    input  logic        end_of_message,
    output logic        in_ready,
    input  sha_status_t status,
    output sha_cmd_t    cmd,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  out_index
);

    state_t     state_reg, state_next;
    logic [6:0] rnd_reg, rnd_next;
    logic [2:0] idx_reg, idx_next;
    logic       fin_reg, fin_next;
    logic       acc;

    assign in_ready  = (state_reg == ST_IDLE);
    assign acc       = in_valid && in_ready;
    assign out_valid = (state_reg == ST_EMIT);
    assign out_index = idx_reg;

    always_comb
    begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        idx_next   = idx_reg;
        fin_next   = fin_reg;
        cmd        = '0;
        cmd.round_idx = rnd_reg[5:0];
        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    cmd.absorb = byte_present;
                    fin_next   = end_of_message;
                    if (byte_present && status.fill == 6'd63)
                    begin
                        cmd.load_work = 1'b1;
                        rnd_next      = '0;
                        state_next    = ST_COMP;
                    end
                    else if (end_of_message)
                        state_next = ST_PAD;
                end
            end
            ST_COMP, ST_COMP1, ST_COMP2:
            begin
                if (rnd_reg == 7'd64)
                begin
                    cmd.add_hash = 1'b1;
                    rnd_next     = '0;
                    if (state_reg == ST_COMP)
                        state_next = fin_reg ? ST_PAD : ST_IDLE;
                    else if (state_reg == ST_COMP1)
                        state_next = ST_ZERO;
                    else
                        state_next = ST_EMIT;
                end
                else
                begin
                    cmd.round = 1'b1;
                    rnd_next  = rnd_reg + 7'd1;
                end
            end
            ST_PAD:
            begin
                cmd.pad_first = 1'b1;
                cmd.load_work = 1'b1;
                if (status.fill >= LenPos)
                    state_next = ST_COMP1;
                else
                begin
                    cmd.set_length = 1'b1;
                    state_next     = ST_COMP2;
                end
            end
            ST_ZERO:
            begin
                cmd.zero_block = 1'b1;
                cmd.set_length = 1'b1;
                cmd.load_work  = 1'b1;
                state_next     = ST_COMP2;
            end
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        cmd.restart = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rnd_reg   <= '0;
            idx_reg   <= '0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            idx_reg   <= idx_next;
            fin_reg   <= fin_next;
        end
    end

endmodule

// ----- hdl/sha256_stream_hash.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hash
// Absorbs a message one byte per transaction and emits the eight-word digest.
//
// Channel  Dir  tdata                  tuser                      tlast
// s_axis   in   msg_byte[7:0]          {end_of_message, present}  -
// m_axis   out  digest_word[31:0]      word_index[2:0]            last_word
//
// A byte is taken while the input is idle; the 64th byte of a block starts 64
// rounds and the hash add, one round a cycle through the shared round logic.
// The final transaction adds one or two padding blocks before the digest words
// are offered one per cycle while the sink accepts them.
// The input waits while a block compresses or the digest drains; reset
// returns the hash words to their initial values.
// ----------------------------------------------------------------------------
module sha256_stream_hash
    import sha256_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // msg_byte
    input  logic [1:0]  s_axis_tuser,   // end_of_message, byte_present
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // digest_word
    output logic [2:0]  m_axis_tuser,   // word_index
    output logic        m_axis_tlast
);

    sha_cmd_t    cmd;
    sha_status_t status;
    word_t       hash_out [8];
    logic [2:0]  idx;

    sha256_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_axis_tvalid),
        .byte_present   (s_axis_tuser[0]),
        .end_of_message (s_axis_tuser[1]),
        .in_ready       (s_axis_tready),
        .status         (status),
        .cmd            (cmd),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_index      (idx)
    );

    sha256_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .byte_in  (s_axis_tdata),
        .status   (status),
        .hash_out (hash_out)
    );

    assign m_axis_tdata = hash_out[idx];
    assign m_axis_tuser = idx;
    assign m_axis_tlast = (idx == 3'd7);

endmodule

// ----- tb/sha256_stream_hash_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hash testbench
// Feeds messages byte by byte with random output gaps and, after the directed
// messages, random input gaps, predicts each eight-word digest in a scoreboard
// and checks every output transaction.
class digest_scoreboard;

    logic [31:0] hash_state [8];
    logic [31:0] block_words [16];
    int          block_fill;
    logic [31:0] bit_length;
    logic [35:0] expected_words [$];
    int          error_count;

    function new();
        error_count = 0;
        restart();
    endfunction

    function void restart();
        for (int i = 0; i < 8; i++)
        begin
            hash_state[i] = sha256_pkg::InitHash[i];
        end
        block_fill = 0;
        bit_length = 0;
    endfunction

    function logic [31:0] rotr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function void place_byte(int pos, logic [7:0] b);
        int wi;
        int sh;
        wi = pos / 4;
        sh = (3 - pos % 4) * 8;
        if (pos % 4 == 0)
        begin
            block_words[wi] = {b, 24'h0};
        end
        else
        begin
            block_words[wi] = (block_words[wi] & ~(32'hff << sh)) | (32'(b) << sh);
        end
    endfunction

    function void compress();
        logic [31:0] r [8];
        logic [31:0] w [64];
        logic [31:0] s0;
        logic [31:0] s1;
        logic [31:0] t1;
        logic [31:0] t2;
        for (int t = 0; t < 64; t++)
        begin
            if (t < 16)
            begin
                w[t] = block_words[t];
            end
            else
            begin
                s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
                s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
                w[t] = w[t-16] + s0 + w[t-7] + s1;
            end
        end
        r = hash_state;
        for (int t = 0; t < 64; t++)
        begin
            s0 = rotr(r[0], 2) ^ rotr(r[0], 13) ^ rotr(r[0], 22);
            t2 = s0 + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
            s1 = rotr(r[4], 6) ^ rotr(r[4], 11) ^ rotr(r[4], 25);
            t1 = r[7] + s1 + ((r[4] & r[5]) ^ (~r[4] & r[6]))
                 + sha256_pkg::RoundConst[t] + w[t];
            r[7] = r[6];
            r[6] = r[5];
            r[5] = r[4];
            r[4] = r[3] + t1;
            r[3] = r[2];
            r[2] = r[1];
            r[1] = r[0];
            r[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
        begin
            hash_state[i] += r[i];
        end
    endfunction

    function void note_input(logic [7:0] msg_byte, logic present, logic finish);
        int p;
        if (present)
        begin
            place_byte(block_fill, msg_byte);
            bit_length += 32'd8;
            block_fill = (block_fill + 1) % 64;
            if (block_fill == 0)
            begin
                compress();
            end
        end
        if (!finish)
        begin
            return;
        end
        p = block_fill;
        place_byte(p, sha256_pkg::PadByte);
        if (p >= 56)
        begin
            for (int i = p + 1; i < 64; i++)
            begin
                place_byte(i, 8'h00);
            end
            compress();
            for (int i = 0; i < 60; i++)
            begin
                place_byte(i, 8'h00);
            end
        end
        else
        begin
            for (int i = p + 1; i < 60; i++)
            begin
                place_byte(i, 8'h00);
            end
        end
        block_words[15] = bit_length;
        compress();
        for (int i = 0; i < 8; i++)
        begin
            expected_words.push_back({i == 7, 3'(i), hash_state[i]});
        end
        restart();
    endfunction

    task report(string msg);
        $display("mismatch: %s", msg);
        error_count++;
    endtask

    task check_result(logic [31:0] word, logic [2:0] index, logic last);
        logic [35:0] e;
        if (expected_words.size() == 0)
        begin
            report($sformatf("unexpected digest word %h", word));
            return;
        end
        e = expected_words.pop_front();
        if (word !== e[31:0] || index !== e[34:32] || last !== e[35])
        begin
            report($sformatf("got %h/%0d/%b, wanted %h/%0d/%b",
                             word, index, last, e[31:0], e[34:32], e[35]));
        end
    endtask

endclass

module sha256_stream_hash_test;

    import sha256_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    digest_scoreboard board;
    int               cycle_count;
    bit               stimulus_done;
    bit               no_gaps;

    sha256_stream_hash i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    task automatic send_item(logic [7:0] msg_byte, logic present, logic finish);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= msg_byte;
        s_axis_tuser  <= {finish, present};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        board.note_input(msg_byte, present, finish);
    endtask

    task automatic send_message(int length, bit end_empty);
        for (int i = 0; i < length; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_item(8'($urandom), 1'b0, 1'b0);
            end
            send_item(8'($urandom), 1'b1, !end_empty && i == length - 1);
        end
        if (end_empty || length == 0)
        begin
            send_item(8'($urandom), 1'b0, 1'b1);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.expected_words.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        board         = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tuser  = 2'b00;
        stimulus_done = 1'b0;
        no_gaps       = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        drain();
        no_gaps = 1'b0;
        send_message(120, 1'b0);
        drain();
        repeat (10) @(posedge clk);
        stimulus_done = 1'b1;
    end

    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            int gap;
            gap = $urandom_range(0, 6);
            if ($urandom_range(0, 3) == 0)
            begin
                gap = 0;
            end
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
            begin
                @(posedge clk);
            end
            board.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (stimulus_done)
            begin
                if (board.error_count == 0 && board.expected_words.size() == 0)
                begin
                    $display("SUCCESS");
                end
                else
                begin
                    $display("FAILURE");
                end
                $finish;
            end
            else if (cycle_count > 400000)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

endmodule

// ----- sha256_stream_hash.f -----
hdl/sha256_pkg.sv
hdl/sha256_datapath.sv
hdl/sha256_ctrl.sv
hdl/sha256_stream_hash.sv
tb/sha256_stream_hash_test.sv
